### hw/rtl/fsac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsac_pkg;

    localparam int WINDOW_TAPS      = 5;
    localparam int ANALOG_CHANNELS  = 5;
    localparam int CONTACT_CHANNELS = 4;
    localparam int SAMPLE_BITS      = 10;

    localparam int WARM_W   = 8;
    localparam int SCALE_W  = 8;
    localparam int VOTE_W   = 3;
    localparam int LEVEL_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [WARM_W-1:0]  WARMUP_RESET = WARM_W'(20);
    localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(90);
    localparam logic [VOTE_W-1:0]  VOTE_RESET   = VOTE_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARMUP = 2'd0,
        CFG_SCALE  = 2'd1,
        CFG_VOTE   = 2'd2
    } t_cfg_idx;

    localparam int CH_W = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(ANALOG_CHANNELS - 1);

    // moving average: window sum and exact floor division by reciprocal
    localparam int AVG_L     = $clog2(WINDOW_TAPS);
    localparam int SUM_W     = SAMPLE_BITS + AVG_L;
    localparam int AVG_SHIFT = SUM_W + AVG_L;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int AVG_RECIP_I = ((1 << AVG_SHIFT) + WINDOW_TAPS - 1) / WINDOW_TAPS;
    localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_I);

    localparam int CSUM_W = $clog2(WINDOW_TAPS + 1);

    localparam int PEAK_W    = SAMPLE_BITS + 1;
    localparam int NUM_RAW_W = SAMPLE_BITS + SCALE_W;
    localparam int DIV_NUM_W = NUM_RAW_W + (NUM_RAW_W % 2);
    localparam int DIV_DEN_W = PEAK_W;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = DIV_NUM_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] analog_0;
        logic [SAMPLE_BITS-1:0] analog_1;
        logic [SAMPLE_BITS-1:0] analog_2;
        logic [SAMPLE_BITS-1:0] analog_3;
        logic [SAMPLE_BITS-1:0] analog_4;
        logic                   contact_0;
        logic                   contact_1;
        logic                   contact_2;
        logic                   contact_3;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_0;
        logic [LEVEL_W-1:0] level_1;
        logic [LEVEL_W-1:0] level_2;
        logic [LEVEL_W-1:0] level_3;
        logic [LEVEL_W-1:0] level_4;
        logic               switch_0;
        logic               switch_1;
        logic               switch_2;
        logic               switch_3;
    } t_out_item;

endpackage

`default_nettype wire

### hw/rtl/flex_sensor_autocal_conditioner_top.sv
// Flex sensor conditioner with self-calibrating range.
// Input channel (i_in_valid / o_in_ready / i_in_item): one item per scan with
// five raw bend samples and four raw contact bits. Output channel
// (o_out_valid / i_out_ready / o_out_item): one item per scan with five
// calibrated levels (0..full_scale) and four debounced switch states.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// 0 warm-up scans, 1 full scale, 2 vote threshold; always ready, write only
// while no scan is in flight.
// Each bend channel steps through window sum, reciprocal multiply, min/max
// update, scale multiply and a pass through the shared radix-4 divider,
// which all five channels use in turn. The contacts are then voted and the
// output register is loaded. One scan is taken at a time: a new item is
// accepted only once the block is back in idle.
// The output register frees the input side: a new item is accepted while an
// earlier result still waits; if the receiver stalls for longer, the block
// holds at the end of the next scan until the output register is taken.
// Reset (synchronous, active low) clears the calibration, the priming of all
// windows and the scan counter and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module flex_sensor_autocal_conditioner_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire fsac_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output fsac_pkg::t_out_item                  o_out_item,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fsac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fsac_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_AVG,
        S_CAL,
        S_MUL,
        S_DIV,
        S_CONTACT,
        S_OUT
    } t_state;

    t_state                           r_state;
    logic [fsac_pkg::CH_W-1:0]        r_ch;
    logic                             r_warm;
    logic                             r_div_start;
    logic                             r_out_valid;
    logic [fsac_pkg::WARM_W-1:0]      r_scan;
    logic [fsac_pkg::WARM_W-1:0]      r_warmup;
    logic [fsac_pkg::SCALE_W-1:0]     r_scale;
    logic [fsac_pkg::VOTE_W-1:0]      r_vote;
    logic                             r_aprimed [fsac_pkg::ANALOG_CHANNELS];
    logic                             r_known   [fsac_pkg::ANALOG_CHANNELS];
    logic                             r_cprimed [fsac_pkg::CONTACT_CHANNELS];

    fsac_pkg::t_in_item               r_in;
    fsac_pkg::t_out_item              r_out;
    logic [fsac_pkg::SAMPLE_BITS-1:0] r_awin
        [fsac_pkg::ANALOG_CHANNELS][fsac_pkg::WINDOW_TAPS];
    logic [fsac_pkg::WINDOW_TAPS-1:0] r_cwin  [fsac_pkg::CONTACT_CHANNELS];
    logic [fsac_pkg::PEAK_W-1:0]      r_peak  [fsac_pkg::ANALOG_CHANNELS];
    logic [fsac_pkg::SAMPLE_BITS-1:0] r_floor [fsac_pkg::ANALOG_CHANNELS];
    logic [fsac_pkg::LEVEL_W-1:0]     r_level [fsac_pkg::ANALOG_CHANNELS];
    logic                             r_sw    [fsac_pkg::CONTACT_CHANNELS];
    logic [fsac_pkg::SUM_W-1:0]       r_sum;
    logic [fsac_pkg::SAMPLE_BITS-1:0] r_v;
    logic [fsac_pkg::DIV_NUM_W-1:0]   r_num;
    logic [fsac_pkg::DIV_DEN_W-1:0]   r_den;

    logic [fsac_pkg::SAMPLE_BITS-1:0] asamp [fsac_pkg::ANALOG_CHANNELS];
    logic                             cbit  [fsac_pkg::CONTACT_CHANNELS];
    logic [fsac_pkg::SAMPLE_BITS-1:0] n_awin [fsac_pkg::WINDOW_TAPS];
    logic [fsac_pkg::SUM_W-1:0]       n_sum;
    logic [fsac_pkg::WINDOW_TAPS-1:0] n_cwin [fsac_pkg::CONTACT_CHANNELS];
    logic                             n_sw   [fsac_pkg::CONTACT_CHANNELS];
    logic [fsac_pkg::PROD_W-1:0]      avg_prod;
    logic [fsac_pkg::SAMPLE_BITS-1:0] span;
    logic                             div_done;
    logic [fsac_pkg::DIV_NUM_W-1:0]   div_quo;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        asamp[0] = r_in.analog_0;
        asamp[1] = r_in.analog_1;
        asamp[2] = r_in.analog_2;
        asamp[3] = r_in.analog_3;
        asamp[4] = r_in.analog_4;
        cbit[0]  = r_in.contact_0;
        cbit[1]  = r_in.contact_1;
        cbit[2]  = r_in.contact_2;
        cbit[3]  = r_in.contact_3;
    end

    // new window of the current channel: shift in, or fill on first sample
    always_comb begin
        n_sum = '0;
        if (r_aprimed[r_ch]) begin
            n_awin[0] = asamp[r_ch];
            for (int t = 1; t < fsac_pkg::WINDOW_TAPS; t++) begin
                n_awin[t] = r_awin[r_ch][t-1];
            end
        end else begin
            for (int t = 0; t < fsac_pkg::WINDOW_TAPS; t++) begin
                n_awin[t] = asamp[r_ch];
            end
        end
        for (int t = 0; t < fsac_pkg::WINDOW_TAPS; t++) begin
            n_sum = n_sum + fsac_pkg::SUM_W'(n_awin[t]);
        end
    end

    always_comb begin
        logic [fsac_pkg::CSUM_W-1:0] csum;
        csum = '0;
        for (int c = 0; c < fsac_pkg::CONTACT_CHANNELS; c++) begin
            if (r_cprimed[c]) begin
                n_cwin[c] = {r_cwin[c][fsac_pkg::WINDOW_TAPS-2:0], cbit[c]};
                csum      = '0;
                for (int t = 0; t < fsac_pkg::WINDOW_TAPS; t++) begin
                    csum = csum + fsac_pkg::CSUM_W'(n_cwin[c][t]);
                end
                n_sw[c] = (int'(csum) > int'(r_vote));
            end else begin
                n_cwin[c] = {fsac_pkg::WINDOW_TAPS{cbit[c]}};
                n_sw[c]   = cbit[c];
            end
        end
    end

    assign avg_prod = fsac_pkg::PROD_W'(r_sum) * fsac_pkg::PROD_W'(fsac_pkg::AVG_RECIP);
    assign span     = r_v - r_floor[r_ch];

    fsac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_warm      <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_warmup    <= fsac_pkg::WARMUP_RESET;
            r_scale     <= fsac_pkg::SCALE_RESET;
            r_vote      <= fsac_pkg::VOTE_RESET;
            for (int a = 0; a < fsac_pkg::ANALOG_CHANNELS; a++) begin
                r_aprimed[a] <= 1'b0;
                r_known[a]   <= 1'b0;
            end
            for (int c = 0; c < fsac_pkg::CONTACT_CHANNELS; c++) begin
                r_cprimed[c] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (fsac_pkg::t_cfg_idx'(i_cfg_index))
                    fsac_pkg::CFG_WARMUP: r_warmup <= i_cfg_data[fsac_pkg::WARM_W-1:0];
                    fsac_pkg::CFG_SCALE:  r_scale  <= i_cfg_data[fsac_pkg::SCALE_W-1:0];
                    fsac_pkg::CFG_VOTE:   r_vote   <= i_cfg_data[fsac_pkg::VOTE_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            r_div_start <= (r_state == S_MUL);
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_warm  <= (r_scan < r_warmup);
                        r_ch    <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_aprimed[r_ch] <= 1'b1;
                    r_state         <= S_AVG;
                end
                S_AVG: begin
                    r_state <= S_CAL;
                end
                S_CAL: begin
                    if (!r_known[r_ch] || ({1'b0, r_v} > r_peak[r_ch])) begin
                        r_known[r_ch] <= 1'b1;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_ch == fsac_pkg::CH_LAST) begin
                            r_state <= S_CONTACT;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_CONTACT: begin
                    for (int c = 0; c < fsac_pkg::CONTACT_CHANNELS; c++) begin
                        r_cprimed[c] <= 1'b1;
                    end
                    if (r_warm) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_in <= i_in_item;
                end
            end
            S_SUM: begin
                for (int t = 0; t < fsac_pkg::WINDOW_TAPS; t++) begin
                    r_awin[r_ch][t] <= n_awin[t];
                end
                r_sum <= n_sum;
            end
            S_AVG: begin
                r_v <= fsac_pkg::SAMPLE_BITS'(avg_prod >> fsac_pkg::AVG_SHIFT);
            end
            S_CAL: begin
                if (!r_known[r_ch] || ({1'b0, r_v} > r_peak[r_ch])) begin
                    r_peak[r_ch] <= fsac_pkg::PEAK_W'({1'b0, r_v}) + fsac_pkg::PEAK_W'(1);
                end
                if (r_warm || (r_v < r_floor[r_ch])) begin
                    r_floor[r_ch] <= r_v;
                end
            end
            S_MUL: begin
                r_num <= fsac_pkg::DIV_NUM_W'(fsac_pkg::DIV_NUM_W'(span) *
                                              fsac_pkg::DIV_NUM_W'(r_scale));
                r_den <= r_peak[r_ch] - fsac_pkg::PEAK_W'(r_floor[r_ch]);
            end
            S_DIV: begin
                if (div_done) begin
                    r_level[r_ch] <= (r_den == '0) ? '0 : div_quo[fsac_pkg::LEVEL_W-1:0];
                end
            end
            S_CONTACT: begin
                for (int c = 0; c < fsac_pkg::CONTACT_CHANNELS; c++) begin
                    r_cwin[c] <= n_cwin[c];
                    r_sw[c]   <= n_sw[c];
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.level_0  <= r_level[0];
                    r_out.level_1  <= r_level[1];
                    r_out.level_2  <= r_level[2];
                    r_out.level_3  <= r_level[3];
                    r_out.level_4  <= r_level[4];
                    r_out.switch_0 <= r_sw[0];
                    r_out.switch_1 <= r_sw[1];
                    r_out.switch_2 <= r_sw[2];
                    r_out.switch_3 <= r_sw[3];
                end
            end
            default: ;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SUM) && (r_ch == '0))
        else $error("accepted item did not start at the first channel");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DIV) && ($past(r_state) == S_MUL))
        else $error("divider started outside the scale step");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV) && !r_div_start)
        else $error("divider finished while not awaited");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_state == S_IDLE) && ($past(r_state) == S_OUT))
        else $error("result shown without finishing a scan");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_ch <= fsac_pkg::CH_LAST))
        else $error("channel counter out of range");

endmodule

`default_nettype wire

### hw/rtl/fsac_div.sv
`timescale 1ns / 1ps
`default_nettype none

module fsac_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [fsac_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [fsac_pkg::DIV_DEN_W-1:0] i_den,
    output logic                                o_done,
    output logic [fsac_pkg::DIV_NUM_W-1:0]      o_quo
);

    logic                           r_busy;
    logic [fsac_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [fsac_pkg::DIV_DEN_W-1:0] r_rem;
    logic [fsac_pkg::DIV_NUM_W-1:0] r_quo;
    logic [fsac_pkg::DIV_DEN_W-1:0] r_den;
    logic [fsac_pkg::DIV_DEN_W-1:0] n_rem;
    logic [fsac_pkg::DIV_NUM_W-1:0] n_quo;

    // restoring division, two quotient bits per cycle while busy
    always_comb begin
        logic [fsac_pkg::DIV_DEN_W:0] part;
        n_rem = r_rem;
        n_quo = r_quo;
        part  = '0;
        for (int k = 0; k < fsac_pkg::DIV_BITS; k++) begin
            part  = {n_rem, n_quo[fsac_pkg::DIV_NUM_W-1]};
            n_quo = {n_quo[fsac_pkg::DIV_NUM_W-2:0], 1'b0};
            if (part >= {1'b0, r_den}) begin
                n_rem    = fsac_pkg::DIV_DEN_W'(part - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = part[fsac_pkg::DIV_DEN_W-1:0];
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = n_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= fsac_pkg::DIV_CNT_W'(fsac_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

endmodule

`default_nettype wire
